// ----- rtl/text_console_engine_unit_macros.svh -----
// Assertion macros shared by the console engine RTL.
`ifndef TEXT_CONSOLE_ENGINE_UNIT_MACROS_SVH
`define TEXT_CONSOLE_ENGINE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under a synchronous reset.
`define TCE_ASSERT_NOW(label, clk, rst, cond, want, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (want)) \
      else $error(msg);
// Next-cycle implication under a synchronous reset.
`define TCE_ASSERT_NEXT(label, clk, rst, cond, want, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (want)) \
      else $error(msg);
`else
`define TCE_ASSERT_NOW(label, clk, rst, cond, want, msg)
`define TCE_ASSERT_NEXT(label, clk, rst, cond, want, msg)
`endif
`endif

// ----- rtl/tce_pkg.sv -----
`default_nettype none
package tce_pkg;

   localparam int DEF_COLS    = 80;
   localparam int DEF_ROWS    = 25;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] CMD_PUT   = 2'd0;
   localparam logic [1:0] CMD_CLEAR = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [7:0] CHAR_BS    = 8'd8;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_FIRST = 8'd32;
   localparam logic [7:0] CHAR_LAST  = 8'd126;
   localparam logic [7:0] CHAR_BLANK = 8'd32;

   localparam logic [3:0] FG_RESET = 4'd10;
   localparam logic [3:0] BG_RESET = 4'd0;
   localparam logic [15:0] RESET_CELL = {BG_RESET, FG_RESET, CHAR_BLANK};

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] REG_FG = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BG = 2'd1;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_PRINT,
      OP_BKSP,
      OP_NEWLINE,
      OP_CLEAR,
      OP_READ
   } tce_op_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  char_code;
      logic        update_caret;
      logic [10:0] cell_index;
   } tce_req_type;

   typedef struct packed {
      logic [6:0]  cursor_col;
      logic [4:0]  cursor_row;
      logic [10:0] cursor_index;
      logic        caret_moved;
      logic [7:0]  read_char;
      logic [7:0]  read_attr;
   } tce_rsp_type;

   typedef struct packed {
      tce_op_type  op;
      logic [7:0]  char_code;
      logic        update_caret;
      logic [10:0] cell_index;
   } tce_entry_type;

endpackage
`default_nettype wire

// ----- rtl/tce_front.sv -----
`default_nettype none
// Decodes an incoming item into an engine operation.
module tce_front #(
   parameter int COLS = tce_pkg::DEF_COLS,
   parameter int ROWS = tce_pkg::DEF_ROWS
) (
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tce_pkg::tce_req_type   req_data,
   input  logic                   q_full,
   input  logic                   initializing,
   output logic                   q_push,
   output tce_pkg::tce_entry_type q_entry
);

   localparam int CELLS = COLS * ROWS;

   assign req_stall = q_full || initializing;
   assign q_push    = req_valid && !req_stall;

   always_comb begin
      q_entry.op           = tce_pkg::OP_NONE;
      q_entry.char_code    = req_data.char_code;
      q_entry.update_caret = req_data.update_caret;
      q_entry.cell_index   = req_data.cell_index;
      case (req_data.cmd)
         tce_pkg::CMD_PUT: begin
            if (req_data.char_code == tce_pkg::CHAR_BS) begin
               q_entry.op = tce_pkg::OP_BKSP;
            end else if (req_data.char_code == tce_pkg::CHAR_LF) begin
               q_entry.op = tce_pkg::OP_NEWLINE;
            end else if (req_data.char_code inside
                         {[tce_pkg::CHAR_FIRST:tce_pkg::CHAR_LAST]}) begin
               q_entry.op = tce_pkg::OP_PRINT;
            end
         end
         tce_pkg::CMD_CLEAR: begin
            q_entry.op = tce_pkg::OP_CLEAR;
         end
         tce_pkg::CMD_READ: begin
            // A read past the screen returns zeros, same as a no-op.
            if (32'(req_data.cell_index) < CELLS) begin
               q_entry.op = tce_pkg::OP_READ;
            end
         end
         default: begin
            q_entry.op = tce_pkg::OP_NONE;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/tce_queue.sv -----
`default_nettype none
// Small FIFO of decoded operations between decode and execution.
module tce_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  tce_pkg::tce_entry_type push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   pop_valid,
   output tce_pkg::tce_entry_type pop_entry
);

   localparam int DEPTH = tce_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   tce_pkg::tce_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/tce_back.sv -----
`default_nettype none
// Executes decoded operations against the screen memory and the cursor.
module tce_back #(
   parameter int COLS = tce_pkg::DEF_COLS,
   parameter int ROWS = tce_pkg::DEF_ROWS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             attr,
   input  logic                   q_valid,
   input  tce_pkg::tce_entry_type q_entry,
   output logic                   q_pop,
   output logic                   initializing,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tce_pkg::tce_rsp_type   rsp_data
);

   localparam int CELLS  = COLS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);
   localparam int COL_W  = $clog2(COLS + 1);
   localparam int ROW_W  = $clog2(ROWS + 1);

   localparam logic [COL_W-1:0] LAST_COL     = COL_W'(COLS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW     = ROW_W'(ROWS - 1);
   localparam logic [CNT_W-1:0] CELL_COUNT   = CNT_W'(CELLS);
   localparam logic [CNT_W-1:0] LAST_CELL    = CNT_W'(CELLS - 1);
   localparam logic [CNT_W-1:0] BOTTOM_START = CNT_W'(CELLS - COLS);
   localparam logic [CNT_W-1:0] ROW_CELLS    = CNT_W'(COLS);

   typedef enum logic [4:0] {
      S_INIT   = 5'b00001,
      S_IDLE   = 5'b00010,
      S_READ   = 5'b00100,
      S_SCROLL = 5'b01000,
      S_FILL   = 5'b10000
   } tce_state_type;

   tce_state_type state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              copy_pend_ff, copy_pend_in;
   logic [ADDR_W-1:0] copy_addr_ff, copy_addr_in;
   logic              moved_ff, moved_in;
   logic [15:0]       fill_value_ff, fill_value_in;
   logic              rsp_valid_ff, rsp_valid_in;
   tce_pkg::tce_rsp_type rsp_data_ff, rsp_data_in;

   logic [15:0]       screen_mem [CELLS];
   logic [15:0]       rd_data_ff;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   logic [ADDR_W-1:0] mem_raddr;
   logic [15:0]       mem_wdata;

   logic              out_free;
   logic              load_rsp;
   logic              res_moved;
   logic [7:0]        res_char;
   logic [7:0]        res_attr;
   logic [ADDR_W-1:0] here_addr;

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign here_addr    = ADDR_W'(32'(row_ff) * COLS + 32'(col_ff));
   assign initializing = (state_ff == S_INIT);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      scan_in       = scan_ff;
      copy_pend_in  = copy_pend_ff;
      copy_addr_in  = copy_addr_ff;
      moved_in      = moved_ff;
      fill_value_in = fill_value_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;
      q_pop         = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = here_addr;
      mem_wdata     = {attr, tce_pkg::CHAR_BLANK};
      mem_raddr     = scan_ff[ADDR_W-1:0];
      load_rsp      = 1'b0;
      res_moved     = 1'b0;
      res_char      = '0;
      res_attr      = '0;

      case (state_ff)
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff[ADDR_W-1:0];
            mem_wdata = tce_pkg::RESET_CELL;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == LAST_CELL) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop     = 1'b1;
               res_moved = q_entry.update_caret;
               case (q_entry.op)
                  tce_pkg::OP_PRINT: begin
                     mem_we    = 1'b1;
                     mem_wdata = {attr, q_entry.char_code};
                     if (col_ff == LAST_COL) begin
                        col_in = '0;
                        row_in = row_ff + 1'b1;
                     end else begin
                        col_in = col_ff + 1'b1;
                     end
                  end
                  tce_pkg::OP_NEWLINE: begin
                     col_in = '0;
                     row_in = row_ff + 1'b1;
                  end
                  tce_pkg::OP_BKSP: begin
                     if (col_ff == '0) begin
                        if (row_ff != '0) begin
                           col_in = LAST_COL;
                           row_in = row_ff - 1'b1;
                        end
                     end else begin
                        col_in = col_ff - 1'b1;
                     end
                     mem_we    = 1'b1;
                     mem_waddr = ADDR_W'(32'(row_in) * COLS + 32'(col_in));
                  end
                  tce_pkg::OP_CLEAR: begin
                     col_in        = '0;
                     row_in        = '0;
                     moved_in      = 1'b0;
                     scan_in       = '0;
                     fill_value_in = {attr, tce_pkg::CHAR_BLANK};
                     state_in      = S_FILL;
                  end
                  tce_pkg::OP_READ: begin
                     mem_raddr = ADDR_W'(q_entry.cell_index);
                     state_in  = S_READ;
                  end
                  default: begin
                     res_moved = 1'b0;
                  end
               endcase
               // Stepping below the last row turns into a scroll.
               if ((q_entry.op == tce_pkg::OP_PRINT || q_entry.op == tce_pkg::OP_NEWLINE)
                   && row_ff == LAST_ROW && col_in == '0) begin
                  row_in        = LAST_ROW;
                  moved_in      = 1'b1;
                  scan_in       = ROW_CELLS;
                  copy_pend_in  = 1'b0;
                  fill_value_in = {attr, tce_pkg::CHAR_BLANK};
                  state_in      = S_SCROLL;
               end else if (q_entry.op != tce_pkg::OP_CLEAR &&
                            q_entry.op != tce_pkg::OP_READ) begin
                  load_rsp = 1'b1;
               end
            end
         end
         S_READ: begin
            load_rsp  = 1'b1;
            res_char  = rd_data_ff[7:0];
            res_attr  = rd_data_ff[15:8];
            state_in  = S_IDLE;
         end
         S_SCROLL: begin
            // Each write copies the word that was read in the cycle before it.
            if (copy_pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = copy_addr_ff;
               mem_wdata = rd_data_ff;
            end
            if (scan_ff != CELL_COUNT) begin
               mem_raddr    = scan_ff[ADDR_W-1:0];
               copy_addr_in = ADDR_W'(scan_ff - ROW_CELLS);
               copy_pend_in = 1'b1;
               scan_in      = scan_ff + 1'b1;
            end else begin
               copy_pend_in = 1'b0;
               scan_in      = BOTTOM_START;
               state_in     = S_FILL;
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff[ADDR_W-1:0];
            mem_wdata = fill_value_ff;
            scan_in   = scan_ff + 1'b1;
            if (scan_ff == LAST_CELL) begin
               load_rsp  = 1'b1;
               res_moved = moved_ff;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.cursor_col   = 7'(col_in);
         rsp_data_in.cursor_row   = 5'(row_in);
         rsp_data_in.cursor_index = 11'(32'(row_in) * COLS + 32'(col_in));
         rsp_data_in.caret_moved  = res_moved;
         rsp_data_in.read_char    = res_char;
         rsp_data_in.read_attr    = res_attr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         scan_ff      <= '0;
         copy_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         scan_ff      <= scan_in;
         copy_pend_ff <= copy_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_addr_ff  <= copy_addr_in;
      moved_ff      <= moved_in;
      fill_value_ff <= fill_value_in;
      rsp_data_ff   <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= screen_mem[mem_raddr];
   end

endmodule
`default_nettype wire

// ----- rtl/text_console_engine_unit.sv -----
`default_nettype none
// Results: put, newline, backspace and no-op items that do not scroll give a registered
// result in the cycle after the queue hands them over; a read first passes the read state.
// Throughput: up to one simple item per cycle while the output is not stalled; a clear holds
// the engine while it fills every cell, and a scroll while it copies all rows but the top up
// one row, then fills the bottom row. Reset: synchronous, active high; afterwards a pass blanks
// the screen and the input stalls until it ends, while configuration writes are taken at once.
module text_console_engine_unit #(
   parameter int COLS = tce_pkg::DEF_COLS,
   parameter int ROWS = tce_pkg::DEF_ROWS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  tce_pkg::tce_req_type              req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output tce_pkg::tce_rsp_type              rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tce_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [3:0]                        csr_wdata
);

`include "text_console_engine_unit_macros.svh"

   // The colour registers form the attribute byte of the cells that items print, erase or fill:
   // background in the high nibble, foreground in the low nibble.
   logic [3:0] fg_ff, fg_in;
   logic [3:0] bg_ff, bg_in;
   logic [7:0] attr;

   // Handshake between decode, the operation queue and the execution engine.
   logic                   q_push;
   logic                   q_full;
   logic                   q_pop;
   logic                   q_valid;
   logic                   initializing;
   tce_pkg::tce_entry_type push_entry;
   tce_pkg::tce_entry_type pop_entry;

   // Configuration writes are always taken; they are registered and apply from the next cycle.
   assign csr_ready = 1'b1;
   assign attr      = {bg_ff, fg_ff};

   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tce_pkg::REG_FG: begin
               fg_in = csr_wdata;
            end
            tce_pkg::REG_BG: begin
               bg_in = csr_wdata;
            end
            default: begin
               fg_in = fg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff <= tce_pkg::FG_RESET;
         bg_ff <= tce_pkg::BG_RESET;
      end else begin
         fg_ff <= fg_in;
         bg_ff <= bg_in;
      end
   end

   // The decoder classifies each item as it arrives and stalls the input only
   // when the queue is full or the screen is still being blanked after reset.
   tce_front #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .q_full       (q_full),
      .initializing (initializing),
      .q_push       (q_push),
      .q_entry      (push_entry)
   );

   // The queue lets new items pile up while the engine walks the screen for a
   // clear or a scroll, or while a finished result waits at the output.
   tce_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   // The engine owns the screen memory, the cursor and the result register.
   tce_back #(
      .COLS (COLS),
      .ROWS (ROWS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .attr         (attr),
      .q_valid      (q_valid),
      .q_entry      (pop_entry),
      .q_pop        (q_pop),
      .initializing (initializing),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

   // No item may enter while the reset blanking pass is running.
   `TCE_ASSERT_NOW(a_init_stalls, clock, reset, initializing, req_stall, "item taken during init")
   // The decoder never pushes into a full queue.
   `TCE_ASSERT_NOW(a_no_overflow, clock, reset, q_push, !q_full, "queue overflow")
   // The engine only takes an operation that the queue holds.
   `TCE_ASSERT_NOW(a_no_underflow, clock, reset, q_pop, q_valid, "queue underflow")
   // A reported cursor column always lies on the screen.
   `TCE_ASSERT_NOW(a_col_range, clock, reset, rsp_valid, 32'(rsp_data.cursor_col) < COLS, "bad column")

endmodule
`default_nettype wire
